// ===== design/bblur_pkg.sv =====
package bblur_pkg;

  // sizes
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int FW_W        = 11;
  localparam int FH_W        = 12;
  localparam int ROW_W       = FH_W + 1;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;

  // register reset values
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 12'd480;

  // reciprocals for division by 3 and by 9, exact for sums below 4096
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] MUL_DIV3 = 15'd21846;
  localparam logic [RECIP_W-1:0] MUL_DIV9 = 15'd7282;
  localparam int CLAMP_MAX   = 255;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

  localparam logic FUNC_PIXEL = 1'b0;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

// ===== design/bblur_ram.sv =====
module bblur_ram #(
  parameter int WIDTH = 2 * bblur_pkg::PIX_W,
  parameter int DEPTH = bblur_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bblur_div.sv =====
module bblur_div (
  input  logic [bblur_pkg::SUM_W-1:0] sum,
  input  logic [bblur_pkg::CNT_W-1:0] count,
  output logic [bblur_pkg::CH_W-1:0]  mean
);

  localparam int PROD_W = bblur_pkg::SUM_W + bblur_pkg::RECIP_W;

  logic [bblur_pkg::SUM_W-1:0]   n;
  logic [bblur_pkg::SUM_W-1:0]   mul_in;
  logic [bblur_pkg::RECIP_W-1:0] recip;
  logic [PROD_W-1:0]             prod;
  logic [bblur_pkg::SUM_W-1:0]   q;

  // round half up: add half the count before the floor division
  assign n = sum + bblur_pkg::SUM_W'(count >> 1);

  // one multiplier serves 3, 6 (halved first) and 9
  assign mul_in = (count == 4'd6) ? (n >> 1) : n;
  assign recip  = (count == 4'd9) ? bblur_pkg::MUL_DIV9 : bblur_pkg::MUL_DIV3;
  assign prod   = PROD_W'(mul_in) * PROD_W'(recip);

  always_comb begin
    case (count)
      4'd1:    q = n;
      4'd2:    q = n >> 1;
      4'd4:    q = n >> 2;
      4'd3, 4'd6, 4'd9: q = bblur_pkg::SUM_W'(prod[PROD_W-1:bblur_pkg::RECIP_SHIFT]);
      default: q = n;
    endcase
  end

  assign mean = (q > bblur_pkg::SUM_W'(bblur_pkg::CLAMP_MAX)) ?
                bblur_pkg::CH_W'(bblur_pkg::CLAMP_MAX) : q[bblur_pkg::CH_W-1:0];

endmodule

// ===== design/box_blur_3x3_edge_mean_top.sv =====
// 3x3 box blur of an RGB stream in raster order, one pixel per clock sustained while out_stall
// is low. Each output channel is the rounded-half-up mean of the in-frame neighbours (9 inside,
// 6 on an edge, 4 in a corner). A result belongs to the pixel one row plus one pixel behind the
// input, so after a frame's last pixel send frame_width+1 drain transactions (func = 1) to flush;
// the last result carries frame_end and the next transaction starts a new frame. Both previous
// rows sit in one line store of MAX_WIDTH entries with a registered read, written back when the
// read stage advances and bypassed when the next pixel hits the same column; a transaction
// passes the read stage and the sum stage into the output register, and a full output register
// holding its stall back does not stop intake until the two inner stages fill. The line store
// needs no clearing after reset. Writing frame_width or frame_height restarts the frame;
// write them only while the block is idle. Widths above MAX_WIDTH are saturated, zero sizes
// read as one.
module box_blur_3x3_edge_mean_top #(
  parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bblur_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [bblur_pkg::CH_W-1:0]         red,
  input  logic [bblur_pkg::CH_W-1:0]         green,
  input  logic [bblur_pkg::CH_W-1:0]         blue,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bblur_pkg::CH_W-1:0]         red_out,
  output logic [bblur_pkg::CH_W-1:0]         green_out,
  output logic [bblur_pkg::CH_W-1:0]         blue_out,
  output logic                               frame_end
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = bblur_pkg::ROW_W;
  localparam int FH_W  = bblur_pkg::FH_W;
  localparam int PIX_W = bblur_pkg::PIX_W;
  localparam int CH_W  = bblur_pkg::CH_W;
  localparam int SUM_W = bblur_pkg::SUM_W;
  localparam int CNT_W = bblur_pkg::CNT_W;

  // configuration
  logic [bblur_pkg::FW_W-1:0] frame_width;
  logic [FH_W-1:0]            frame_height;
  logic [WW-1:0]              eff_w;
  logic [FH_W-1:0]            eff_h;

  // position counters
  logic [AW-1:0]    in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [AW-1:0]    out_column, out_column_next;
  logic [FH_W-1:0]  out_row, out_row_next;

  // handshake
  logic acc, a_adv, b_adv, out_ready, b_ready;

  // per-transaction decode at intake
  bblur_pkg::pixel_t acc_pix;
  logic              acc_emit, acc_last;
  logic              acc_use_c0, acc_use_c2, acc_use_r0, acc_use_r2;
  logic [WW-1:0]     col_inc, ocol_inc;
  logic [ROW_W-1:0]  orow_inc;

  // stage a: line store read returns here
  logic              a_valid;
  bblur_pkg::pixel_t a_pix;
  logic [AW-1:0]     a_addr;
  logic              a_emit, a_last;
  logic              a_use_c0, a_use_c2, a_use_r0, a_use_r2;
  logic              a_fwd;
  bblur_pkg::pixel_t a_fwd_up, a_fwd_mid;
  bblur_pkg::pixel_t a_up_eff, a_mid_eff;
  logic [2*PIX_W-1:0] ram_q;

  // window, [column][row], column 2 newest
  bblur_pkg::pixel_t win [3][3];
  bblur_pkg::pixel_t win_next [3][3];

  // stage b: sums and counts
  logic             b_valid;
  logic [SUM_W-1:0] b_sum [3];
  logic [CNT_W-1:0] b_count;
  logic             b_last;
  logic [SUM_W-1:0] sum_next [3];
  logic [1:0]       ncols, nrows;
  logic [CH_W-1:0]  mean [3];

  // ---------------------------------------------------------------------------
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bblur_pkg::FW_RESET;
      frame_height <= bblur_pkg::FH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bblur_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[bblur_pkg::FW_W-1:0];
        bblur_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: each stage moves when the one after it has room; stage a also moves when it emits no result
  assign out_ready = !out_valid || !out_stall;
  assign b_ready   = !b_valid || out_ready;
  assign b_adv     = b_valid && out_ready;
  assign a_adv     = a_valid && (b_ready || !a_emit);
  assign in_stall  = a_valid && !a_adv;
  assign acc       = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // intake: counters and neighbour flags
  assign col_inc  = WW'(in_column) + WW'(1);
  assign ocol_inc = WW'(out_column) + WW'(1);
  assign orow_inc = ROW_W'(out_row) + ROW_W'(1);

  always_comb begin
    acc_pix    = ((in_row < ROW_W'(eff_h)) && (func == bblur_pkg::FUNC_PIXEL)) ?
                 {red, green, blue} : '0;
    acc_emit   = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));
    acc_use_c0 = (out_column != '0);
    acc_use_c2 = (ocol_inc < eff_w);
    acc_use_r0 = (out_row != '0);
    acc_use_r2 = (orow_inc < ROW_W'(eff_h));
    acc_last   = !acc_use_r2 && !acc_use_c2;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;

    if (acc) begin
      if (col_inc >= eff_w) begin
        in_column_next = '0;
        in_row_next    = in_row + ROW_W'(1);
      end else begin
        in_column_next = col_inc[AW-1:0];
      end
      if (acc_emit) begin
        if (acc_last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (ocol_inc >= eff_w) begin
          out_column_next = '0;
          out_row_next    = out_row + FH_W'(1);
        end else begin
          out_column_next = ocol_inc[AW-1:0];
        end
      end
    end

    // a register write restarts the frame
    if (cfg_write) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // line store: {upper row, middle row} per column
  bblur_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (a_adv),
    .waddr (a_addr),
    .wdata ({a_mid_eff, a_pix}),
    .re    (acc),
    .raddr (in_column),
    .rdata (ram_q)
  );

  // bypass when the pixel ahead writes the column being read in the same cycle
  assign a_up_eff  = a_fwd ? a_fwd_up  : ram_q[2*PIX_W-1:PIX_W];
  assign a_mid_eff = a_fwd ? a_fwd_mid : ram_q[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pix     <= acc_pix;
      a_addr    <= in_column;
      a_emit    <= acc_emit;
      a_last    <= acc_last;
      a_use_c0  <= acc_use_c0;
      a_use_c2  <= acc_use_c2;
      a_use_r0  <= acc_use_r0;
      a_use_r2  <= acc_use_r2;
      a_fwd     <= a_adv && (a_addr == in_column);
      a_fwd_up  <= a_mid_eff;
      a_fwd_mid <= a_pix;
    end
  end

  // ---------------------------------------------------------------------------
  // window shift and masked sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[0][r] = win[1][r];
      win_next[1][r] = win[2][r];
    end
    win_next[2][0] = a_up_eff;
    win_next[2][1] = a_mid_eff;
    win_next[2][2] = a_pix;
  end

  always_comb begin
    logic [SUM_W-1:0] col_sum [3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 3; k++) begin
        col_sum[k] = SUM_W'(win_next[k][1][CH_W*ch +: CH_W])
                   + (a_use_r0 ? SUM_W'(win_next[k][0][CH_W*ch +: CH_W]) : '0)
                   + (a_use_r2 ? SUM_W'(win_next[k][2][CH_W*ch +: CH_W]) : '0);
      end
      sum_next[ch] = col_sum[1] + (a_use_c0 ? col_sum[0] : '0)
                   + (a_use_c2 ? col_sum[2] : '0);
    end
  end

  assign ncols = 2'd1 + 2'(a_use_c0) + 2'(a_use_c2);
  assign nrows = 2'd1 + 2'(a_use_r0) + 2'(a_use_r2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          win[k][r] <= '0;
        end
      end
    end else if (a_adv) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv && a_emit) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_emit) begin
      b_sum   <= sum_next;
      b_count <= CNT_W'(ncols) * CNT_W'(nrows);
      b_last  <= a_last;
    end
  end

  // ---------------------------------------------------------------------------
  // rounded mean per channel into the output register
  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    bblur_div u_div (
      .sum   (b_sum[ch]),
      .count (b_count),
      .mean  (mean[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      red_out   <= mean[2];
      green_out <= mean[1];
      blue_out  <= mean[0];
      frame_end <= b_last;
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WW'(in_column) < eff_w)
    else $error("input column beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    in_row <= ROW_W'(eff_h) + ROW_W'(1))
    else $error("input row beyond drain row");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> !in_stall)
    else $error("intake stalled with empty read stage");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_count == 4'd1 || b_count == 4'd2 || b_count == 4'd3 ||
                 b_count == 4'd4 || b_count == 4'd6 || b_count == 4'd9))
    else $error("neighbour count not a product of row and column counts");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    acc && acc_emit && acc_last |=>
      (in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0))
    else $error("counters not restarted after last pixel of frame");
`endif

endmodule
